@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL; empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

@@ rtl/core/ncnud_pkg.sv @@
// ----------------------------------------------------------------------------
// ncnud_pkg
// Types and constants of the neighbor cache with unreachability handling.
// ----------------------------------------------------------------------------
package ncnud_pkg;
    localparam int CACHE_DEPTH     = 8;
    localparam int IDX_W           = $clog2(CACHE_DEPTH);
    localparam int MAX_SOLICIT_OUT = 8;
    localparam int SOL_CNT_W       = $clog2(MAX_SOLICIT_OUT + 1);
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        RK_LOOKUP  = 2'd0,
        RK_ADD     = 2'd1,
        RK_SOLICIT = 2'd2,
        RK_DONE    = 2'd3
    } t_kind;

    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_REACHABLE  = 3'd2;
    localparam logic [2:0] ST_STALE      = 3'd3;
    localparam logic [2:0] ST_DELAY      = 3'd4;
    localparam logic [2:0] ST_PROBE      = 3'd5;

    localparam logic [1:0] CFG_MAX_MC = 2'd0;
    localparam logic [1:0] CFG_MAX_UC = 2'd1;
    localparam logic [1:0] CFG_RETX   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_ADD,
        S_WALK,
        S_DONE
    } t_state;
endpackage

@@ rtl/core/neighbor_cache_unreachability_fsm.sv @@
// ----------------------------------------------------------------------------
// neighbor_cache_unreachability_fsm
// Eight-entry IPv6 neighbor cache with lookup, add and periodic tick scan.
// ----------------------------------------------------------------------------
// One request at a time. A lookup visits one entry a cycle and answers at the
// first match or at the last entry. An add visits entries until a free slot
// (or the LFSR pick when full). A tick runs every entry once through the shared
// per-entry timer/state unit, one entry a cycle, emitting each solicitation in
// the same cycle up to MAX_SOLICIT_OUT per tick, then sends a done result. A
// full output register holds the sequencer while the receiver stalls a waiting
// result.
module neighbor_cache_unreachability_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [47:0] i_link_address,
    input  logic        i_link_present,
    input  logic        i_router_flag,
    input  logic [2:0]  i_initial_state,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic        o_hit,
    output logic [2:0]  o_entry_index,
    output logic [47:0] o_link_out,
    output logic        o_router_out,
    output logic [2:0]  o_state_out,
    output logic [63:0] o_target_high,
    output logic [63:0] o_target_low,
    output logic        o_unicast,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import ncnud_pkg::*;
`include "assert_macros.svh"

    typedef logic [IDX_W-1:0] t_idx;

    t_state r_state, n_state;
    t_idx   r_idx;
    logic [SOL_CNT_W-1:0] r_sol_cnt;
    logic [15:0] r_lfsr;
    logic [3:0]  r_max_mc, r_max_uc;
    logic [7:0]  r_retx;

    // request registers
    logic [63:0] r_req_ah, r_req_al;
    logic [47:0] r_req_link;
    logic        r_req_router;
    logic [2:0]  r_req_state;

    // entry store
    logic [CACHE_DEPTH-1:0] r_valid;
    logic [63:0] r_ah    [CACHE_DEPTH];
    logic [63:0] r_al    [CACHE_DEPTH];
    logic [47:0] r_link  [CACHE_DEPTH];
    logic        r_rtr   [CACHE_DEPTH];
    logic [2:0]  r_st    [CACHE_DEPTH];
    logic [15:0] r_rch_cd[CACHE_DEPTH];
    logic [7:0]  r_rsd_cd[CACHE_DEPTH];
    logic [3:0]  r_snd   [CACHE_DEPTH];

    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic        r_hit, r_rtr_o, r_uni, r_last;
    logic [2:0]  r_eidx, r_st_o;
    logic [47:0] r_link_o;
    logic [63:0] r_th, r_tl;

    logic in_accept, can_emit, is_last_idx;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign can_emit    = !r_out_valid || !i_out_stall;
    assign is_last_idx = (r_idx == t_idx'(CACHE_DEPTH - 1));

    // shared per-entry unit: countdowns and reachability transition
    logic [15:0] u_rch;
    logic [7:0]  u_rsd;
    logic [3:0]  u_snd;
    logic [2:0]  u_st;
    logic        u_drop, u_emit, u_uni;
    always_comb begin
        u_rch  = (r_rch_cd[r_idx] != 16'd0) ? r_rch_cd[r_idx] - 16'd1 : 16'd0;
        u_rsd  = (r_rsd_cd[r_idx] != 8'd0) ? r_rsd_cd[r_idx] - 8'd1 : 8'd0;
        u_snd  = r_snd[r_idx];
        u_st   = r_st[r_idx];
        u_drop = 1'b0;
        u_emit = 1'b0;
        u_uni  = 1'b0;
        case (r_st[r_idx])
            ST_INCOMPLETE: begin
                if (r_snd[r_idx] >= r_max_mc) begin
                    u_drop = 1'b1;
                end else if (u_rsd == 8'd0) begin
                    u_emit = 1'b1;
                    u_rsd  = r_retx;
                    u_snd  = r_snd[r_idx] + 4'd1;
                end
            end
            ST_REACHABLE: begin
                if (u_rch == 16'd0) begin
                    u_st  = ST_STALE;
                    u_snd = 4'd0;
                end
            end
            ST_DELAY: begin
                if (u_rch == 16'd0) begin
                    u_st   = ST_PROBE;
                    u_emit = 1'b1;
                    u_uni  = 1'b1;
                    u_rsd  = r_retx;
                    u_snd  = 4'd1;
                end
            end
            ST_PROBE: begin
                if (r_snd[r_idx] >= r_max_uc) begin
                    u_snd  = 4'd0;
                    u_drop = 1'b1;
                end else if (u_rsd == 8'd0) begin
                    u_emit = 1'b1;
                    u_uni  = 1'b1;
                    u_rsd  = r_retx;
                    u_snd  = r_snd[r_idx] + 4'd1;
                end
            end
            default: ;
        endcase
    end

    logic        lk_match, add_free, report;
    logic [15:0] lfsr_next;
    t_idx        add_slot;
    assign lk_match  = r_valid[r_idx] && (r_ah[r_idx] == r_req_ah)
                       && (r_al[r_idx] == r_req_al);
    assign add_free  = !r_valid[r_idx];
    assign lfsr_next = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
    assign add_slot  = add_free ? r_idx : lfsr_next[IDX_W-1:0];
    assign report    = r_valid[r_idx] && u_emit
                       && (r_sol_cnt < SOL_CNT_W'(MAX_SOLICIT_OUT));

    // sequencer decisions
    logic do_lookup_out, do_add, do_walk, do_done, emit_now;
    always_comb begin
        n_state       = r_state;
        do_lookup_out = 1'b0;
        do_add        = 1'b0;
        do_walk       = 1'b0;
        do_done       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_LOOKUP: n_state = S_LOOKUP;
                        OP_ADD:    n_state = S_ADD;
                        OP_TICK:   n_state = S_WALK;
                        OP_NONE:   n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                if ((lk_match || is_last_idx) && can_emit) begin
                    do_lookup_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_ADD: begin
                if ((add_free || is_last_idx) && can_emit) begin
                    do_add  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (!report || can_emit) begin
                    do_walk = 1'b1;
                    if (is_last_idx) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    do_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign emit_now = do_lookup_out || do_add || (do_walk && report) || do_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control, config, scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sol_cnt   <= '0;
            r_lfsr      <= LFSR_SEED;
            r_max_mc    <= 4'd3;
            r_max_uc    <= 4'd3;
            r_retx      <= 8'd1;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_MC: r_max_mc <= i_cfg_data[3:0];
                    CFG_MAX_UC: r_max_uc <= i_cfg_data[3:0];
                    CFG_RETX:   r_retx   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_idx     <= '0;
                r_sol_cnt <= '0;
            end else if ((r_state == S_LOOKUP && !lk_match) ||
                         (r_state == S_ADD && !add_free) || do_walk) begin
                // advance scan; the exits above override where needed
                r_idx <= r_idx + t_idx'(1);
            end
            if (do_walk && report) begin
                r_sol_cnt <= r_sol_cnt + SOL_CNT_W'(1);
            end
            if (do_add) begin
                if (!add_free) begin
                    r_lfsr <= lfsr_next;
                end
                r_valid[add_slot] <= 1'b1;
            end
            if (do_walk && r_valid[r_idx] && u_drop) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // entry payload and request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_ah     <= i_addr_high;
            r_req_al     <= i_addr_low;
            r_req_link   <= i_link_present ? i_link_address : 48'd0;
            r_req_router <= i_router_flag;
            r_req_state  <= i_initial_state;
        end
        if (do_add) begin
            r_ah[add_slot]     <= r_req_ah;
            r_al[add_slot]     <= r_req_al;
            r_link[add_slot]   <= r_req_link;
            r_rtr[add_slot]    <= r_req_router;
            r_st[add_slot]     <= r_req_state;
            r_rch_cd[add_slot] <= 16'd0;
            r_rsd_cd[add_slot] <= 8'd0;
            r_snd[add_slot]    <= 4'd0;
        end
        if (do_walk && r_valid[r_idx]) begin
            r_rch_cd[r_idx] <= u_rch;
            r_rsd_cd[r_idx] <= u_rsd;
            r_snd[r_idx]    <= u_snd;
            r_st[r_idx]     <= u_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_hit    <= 1'b0;
            r_eidx   <= 3'd0;
            r_link_o <= 48'd0;
            r_rtr_o  <= 1'b0;
            r_st_o   <= 3'd0;
            r_th     <= 64'd0;
            r_tl     <= 64'd0;
            r_uni    <= 1'b0;
            r_last   <= 1'b1;
            if (do_lookup_out) begin
                r_kind <= RK_LOOKUP;
                if (lk_match) begin
                    r_hit    <= 1'b1;
                    r_eidx   <= 3'(r_idx);
                    r_link_o <= r_link[r_idx];
                    r_rtr_o  <= r_rtr[r_idx];
                    r_st_o   <= r_st[r_idx];
                end
            end else if (do_add) begin
                r_kind   <= RK_ADD;
                r_hit    <= !add_free;
                r_eidx   <= 3'(add_slot);
                r_link_o <= r_req_link;
                r_rtr_o  <= r_req_router;
                r_st_o   <= r_req_state;
            end else if (do_walk) begin
                r_kind   <= RK_SOLICIT;
                r_eidx   <= 3'(r_idx);
                r_link_o <= r_link[r_idx];
                r_rtr_o  <= r_rtr[r_idx];
                r_st_o   <= u_st;
                r_th     <= r_ah[r_idx];
                r_tl     <= r_al[r_idx];
                r_uni    <= u_uni;
                r_last   <= 1'b0;
            end else begin
                r_kind <= RK_DONE;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_hit         = r_hit;
    assign o_entry_index = r_eidx;
    assign o_link_out    = r_link_o;
    assign o_router_out  = r_rtr_o;
    assign o_state_out   = r_st_o;
    assign o_target_high = r_th;
    assign o_target_low  = r_tl;
    assign o_unicast     = r_uni;
    assign o_last        = r_last;

    `ASSERT_IMPL(a_sol_bound, i_clk, i_rst_n, 1'b1, r_sol_cnt <= SOL_CNT_W'(MAX_SOLICIT_OUT))
    `ASSERT_NEXT(a_busy_after_op, i_clk, i_rst_n, in_accept && i_opcode != OP_NONE, r_state != S_IDLE)
    `ASSERT_IMPL(a_one_emit, i_clk, i_rst_n, emit_now, can_emit)
    `ASSERT_NEXT(a_done_last, i_clk, i_rst_n, do_done, r_out_valid && r_last)
endmodule
